[hdl/scap_pkg.sv]
// ----------------------------------------------------------------------------
// scap_pkg
// Types and constants shared by the cell address parser modules.
// ----------------------------------------------------------------------------
package scap_pkg;

  // Widths of the item fields.
  localparam int unsigned CharW   = 8;
  localparam int unsigned StatusW = 3;
  localparam int unsigned RowW    = 21;
  localparam int unsigned ColW    = 15;
  localparam int unsigned ValW    = 5;

  // Register indexes of the configuration port.
  localparam logic REG_ROW_LIMIT    = 1'b0;
  localparam logic REG_COLUMN_LIMIT = 1'b1;

  // Reset values of the limit registers.
  localparam logic [RowW-1:0] ROW_LIMIT_RST    = 21'd1048576;
  localparam logic [ColW-1:0] COLUMN_LIMIT_RST = 15'd16384;

  // Saturation values of the accumulators.
  localparam logic [RowW-1:0] ROW_SAT = 21'h1FFFFF;
  localparam logic [ColW-1:0] COL_SAT = 15'h7FFF;

  // Result status codes, in order of precedence.
  localparam logic [StatusW-1:0] ST_OK        = 3'd0;
  localparam logic [StatusW-1:0] ST_EMPTY     = 3'd1;
  localparam logic [StatusW-1:0] ST_FORM      = 3'd2;
  localparam logic [StatusW-1:0] ST_BAD_CHAR  = 3'd3;
  localparam logic [StatusW-1:0] ST_LEAD_ZERO = 3'd4;
  localparam logic [StatusW-1:0] ST_ROW_RANGE = 3'd5;
  localparam logic [StatusW-1:0] ST_COL_RANGE = 3'd6;

  // Parse phases.
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_LETTERS = 2'd1;
  localparam logic [1:0] PH_DIGITS  = 2'd2;
  localparam logic [1:0] PH_FAIL    = 2'd3;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_BLANK,
    KIND_LETTER,
    KIND_DIGIT,
    KIND_OTHER
  } char_kind_e;

  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             char_present;
    logic             last_char;
  } in_item_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [RowW-1:0]    row_number;
    logic [ColW-1:0]    column_number;
  } out_item_t;

  // A classified character as it travels from the front to the back.
  typedef struct packed {
    char_kind_e      kind;
    logic [ValW-1:0] value;
    logic            last;
  } class_item_t;

  typedef struct packed {
    logic [RowW-1:0] row_limit;
    logic [ColW-1:0] column_limit;
  } cfg_t;

endpackage

[hdl/scap_front.sv]
// ----------------------------------------------------------------------------
// scap_front
// Classifies one input character as blank, letter, digit or other.
// ----------------------------------------------------------------------------
module scap_front (
  input  scap_pkg::in_item_t    item_i,
  output scap_pkg::class_item_t class_o
);

  logic [scap_pkg::CharW-1:0] folded;
  logic                       blank;
  logic                       letter;
  logic                       digit;

  always_comb begin
    // Lower case letters are folded to upper case.
    if (item_i.char_code >= 8'd97 && item_i.char_code <= 8'd122) begin
      folded = item_i.char_code - 8'd32;
    end else begin
      folded = item_i.char_code;
    end
    blank  = (item_i.char_code == 8'd9)  || (item_i.char_code == 8'd10) ||
             (item_i.char_code == 8'd12) || (item_i.char_code == 8'd13) ||
             (item_i.char_code == 8'd32);
    letter = (folded >= 8'd65) && (folded <= 8'd90);
    digit  = (folded >= 8'd48) && (folded <= 8'd57);

    class_o.last  = item_i.last_char;
    class_o.value = '0;
    if (!item_i.char_present) begin
      class_o.kind = scap_pkg::KIND_NONE;
    end else if (blank) begin
      class_o.kind = scap_pkg::KIND_BLANK;
    end else if (letter) begin
      class_o.kind  = scap_pkg::KIND_LETTER;
      class_o.value = 5'(folded - 8'd64);
    end else if (digit) begin
      class_o.kind  = scap_pkg::KIND_DIGIT;
      class_o.value = 5'(folded - 8'd48);
    end else begin
      class_o.kind = scap_pkg::KIND_OTHER;
    end
  end

endmodule

[hdl/scap_queue.sv]
// ----------------------------------------------------------------------------
// scap_queue
// Two-entry queue of classified characters between front and back.
// ----------------------------------------------------------------------------
module scap_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  scap_pkg::class_item_t push_item_i,
  output logic                  full_o,
  output logic                  valid_o,
  input  logic                  pop_i,
  output scap_pkg::class_item_t pop_item_o
);

  scap_pkg::class_item_t entry_q [2];
  logic                  wr_ptr_q, wr_ptr_d;
  logic                  rd_ptr_q, rd_ptr_d;
  logic [1:0]            count_q, count_d;
  logic                  do_push;
  logic                  do_pop;

  assign full_o     = (count_q == 2'd2);
  assign valid_o    = (count_q != 2'd0);
  assign pop_item_o = entry_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

[hdl/scap_back.sv]
// ----------------------------------------------------------------------------
// scap_back
// Parses classified characters, keeps the accumulators and holds the result.
// ----------------------------------------------------------------------------
module scap_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  scap_pkg::cfg_t        cfg_i,
  input  logic                  valid_i,
  input  scap_pkg::class_item_t item_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output scap_pkg::out_item_t   out_item_o
);

  localparam int unsigned RowMulW = scap_pkg::RowW + 4;
  localparam int unsigned ColMulW = scap_pkg::ColW + 5;

  // Parse state.
  logic [1:0]                phase_q, phase_d;
  logic [scap_pkg::ColW-1:0] col_q, col_d;
  logic [scap_pkg::RowW-1:0] row_q, row_d;
  logic [1:0]                cnt_q, cnt_d;
  logic                      fdz_q, fdz_d;
  logic                      pend_q, pend_d;
  logic                      bad_q, bad_d;

  // Result register: the parse state captured at the last character.
  logic                      res_valid_q;
  logic [1:0]                res_phase_q;
  logic [scap_pkg::ColW-1:0] res_col_q;
  logic [scap_pkg::RowW-1:0] res_row_q;
  logic [1:0]                res_cnt_q;
  logic                      res_fdz_q;
  logic                      res_bad_q;

  logic                      res_free;
  logic [RowMulW-1:0]        row_mul;
  logic [ColMulW-1:0]        col_mul;
  logic [scap_pkg::StatusW-1:0] status;

  assign res_free = !res_valid_q || !out_stall_i;
  assign pop_o    = valid_i && (!item_i.last || res_free);

  always_comb begin
    row_mul = (RowMulW'(row_q) << 3) + (RowMulW'(row_q) << 1) + RowMulW'(item_i.value);
    col_mul = (ColMulW'(col_q) << 4) + (ColMulW'(col_q) << 3) + (ColMulW'(col_q) << 1)
            + ColMulW'(item_i.value);

    phase_d = phase_q;
    col_d   = col_q;
    row_d   = row_q;
    cnt_d   = cnt_q;
    fdz_d   = fdz_q;
    pend_d  = pend_q;
    bad_d   = bad_q;

    if (item_i.kind == scap_pkg::KIND_BLANK) begin
      // A blank after content may be trailing; it is bad only if more follows.
      if (phase_q == scap_pkg::PH_LETTERS || phase_q == scap_pkg::PH_DIGITS) begin
        pend_d = 1'b1;
      end
    end else if (item_i.kind != scap_pkg::KIND_NONE) begin
      if (phase_q == scap_pkg::PH_IDLE) begin
        if (item_i.kind == scap_pkg::KIND_LETTER) begin
          phase_d = scap_pkg::PH_LETTERS;
          col_d   = scap_pkg::ColW'(item_i.value);
        end else begin
          phase_d = scap_pkg::PH_FAIL;
        end
      end else if (phase_q != scap_pkg::PH_FAIL) begin
        if (pend_q) begin
          pend_d  = 1'b0;
          phase_d = scap_pkg::PH_DIGITS;
          bad_d   = 1'b1;
        end
        if (phase_d == scap_pkg::PH_LETTERS && item_i.kind == scap_pkg::KIND_LETTER) begin
          col_d = (col_mul > ColMulW'(scap_pkg::COL_SAT)) ? scap_pkg::COL_SAT
                                                            : col_mul[scap_pkg::ColW-1:0];
        end else begin
          phase_d = scap_pkg::PH_DIGITS;
          if (item_i.kind == scap_pkg::KIND_DIGIT) begin
            if (cnt_q == 2'd0) begin
              fdz_d = (item_i.value == '0);
            end
            if (cnt_q != 2'd2) begin
              cnt_d = cnt_q + 2'd1;
            end
            row_d = (row_mul > RowMulW'(scap_pkg::ROW_SAT)) ? scap_pkg::ROW_SAT
                                                              : row_mul[scap_pkg::RowW-1:0];
          end else begin
            bad_d = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= scap_pkg::PH_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      cnt_q       <= 2'd0;
      fdz_q       <= 1'b0;
      pend_q      <= 1'b0;
      bad_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        if (item_i.last) begin
          phase_q <= scap_pkg::PH_IDLE;
          col_q   <= '0;
          row_q   <= '0;
          cnt_q   <= 2'd0;
          fdz_q   <= 1'b0;
          pend_q  <= 1'b0;
          bad_q   <= 1'b0;
        end else begin
          phase_q <= phase_d;
          col_q   <= col_d;
          row_q   <= row_d;
          cnt_q   <= cnt_d;
          fdz_q   <= fdz_d;
          pend_q  <= pend_d;
          bad_q   <= bad_d;
        end
      end
      if (pop_o && item_i.last) begin
        res_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && item_i.last) begin
      res_phase_q <= phase_d;
      res_col_q   <= col_d;
      res_row_q   <= row_d;
      res_cnt_q   <= cnt_d;
      res_fdz_q   <= fdz_d;
      res_bad_q   <= bad_d;
    end
  end

  // Status checks in order of precedence.
  always_comb begin
    if (res_phase_q == scap_pkg::PH_IDLE) begin
      status = scap_pkg::ST_EMPTY;
    end else if (res_phase_q == scap_pkg::PH_LETTERS || res_phase_q == scap_pkg::PH_FAIL) begin
      status = scap_pkg::ST_FORM;
    end else if (res_bad_q) begin
      status = scap_pkg::ST_BAD_CHAR;
    end else if (res_cnt_q == 2'd2 && res_fdz_q) begin
      status = scap_pkg::ST_LEAD_ZERO;
    end else if (res_row_q == '0 || res_row_q > cfg_i.row_limit) begin
      status = scap_pkg::ST_ROW_RANGE;
    end else if (res_col_q > cfg_i.column_limit) begin
      status = scap_pkg::ST_COL_RANGE;
    end else begin
      status = scap_pkg::ST_OK;
    end
    out_item_o.status        = status;
    out_item_o.row_number    = (status == scap_pkg::ST_OK) ? res_row_q : '0;
    out_item_o.column_number = (status == scap_pkg::ST_OK) ? res_col_q : '0;
  end

  assign out_valid_o = res_valid_q;

endmodule

[hdl/spreadsheet_cell_address_parser_top.sv]
// ----------------------------------------------------------------------------
// spreadsheet_cell_address_parser_top
// Parses an A1-style cell reference, one character per item, into a status,
// a row number and a bijective base-26 column number.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i / in_stall_o  scap_pkg::in_item_t
// out       output     out_valid_o / out_stall_i scap_pkg::out_item_t
// cfg       input      cfg_we_i                 cfg_idx_i, cfg_data_i
//
// One character item is taken per cycle unless the queue is full. An accepted item
// enters the two-entry queue and is parsed once it reaches the head; a last
// character then loads the result register, from which the result is offered.
// Reset clears the parse state, queue and result and sets the limits to 1048576
// rows and 16384 columns. A stalled result lets other characters flow until the
// queue fills; a last character waits at the head until the result is taken.
//
module spreadsheet_cell_address_parser_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  scap_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output scap_pkg::out_item_t           out_item_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [scap_pkg::RowW-1:0]     cfg_data_i
);

  // Limit registers; the user must write them only while the block is idle, which the block itself does not enforce.
  scap_pkg::cfg_t        cfg_q;
  scap_pkg::class_item_t front_class;
  scap_pkg::class_item_t queue_item;
  logic                  queue_full;
  logic                  queue_valid;
  logic                  back_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_limit    <= scap_pkg::ROW_LIMIT_RST;
      cfg_q.column_limit <= scap_pkg::COLUMN_LIMIT_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == scap_pkg::REG_ROW_LIMIT) begin
        cfg_q.row_limit <= cfg_data_i;
      end else begin
        cfg_q.column_limit <= cfg_data_i[scap_pkg::ColW-1:0];
      end
    end
  end

  // The front classifies the character; classification needs no state.
  scap_front u_front (
    .item_i  (in_item_i),
    .class_o (front_class)
  );

  // The queue decouples the front from the back, so that a stalled result
  // does not stop characters from being taken in until the queue fills.
  scap_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_item_i (front_class),
    .full_o      (queue_full),
    .valid_o     (queue_valid),
    .pop_i       (back_pop),
    .pop_item_o  (queue_item)
  );

  assign in_stall_o = queue_full;

  // The back holds the parse state and the result register.
  scap_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .valid_i     (queue_valid),
    .item_i      (queue_item),
    .pop_o       (back_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

[hdl/scap_checker.sv]
// ----------------------------------------------------------------------------
// scap_checker
// Port-level checks on the cell address parser, attached by bind.
// ----------------------------------------------------------------------------
module scap_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input scap_pkg::out_item_t out_item_o
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("result changed while stalled");

  // A good reference always names a real row and column.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == scap_pkg::ST_OK |->
      out_item_o.row_number != '0 && out_item_o.column_number != '0)
    else $error("ok result with zero row or column");

  // A failed reference reports zero row and column, and a known status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != scap_pkg::ST_OK |->
      out_item_o.row_number == '0 && out_item_o.column_number == '0 &&
      out_item_o.status != 3'd7)
    else $error("failed result carries a position");

endmodule

bind spreadsheet_cell_address_parser_top scap_checker u_scap_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// Cell address parser testbench
// Sends A1-style cell references to the parser one character item at a
// time and compares every status, row and column against a predictor that
// runs alongside, under both default and rewritten row and column limits.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import scap_pkg::*;

  // A generous ceiling on the run, well above the slowest legal run with
  // full back-pressure on both sides.
  localparam int unsigned CYCLE_LIMIT = 200000;
  // Cycles to let pass after the last result before touching the limits,
  // since characters without a result may still be in the pipeline.
  localparam int unsigned SETTLE_CYCLES = 8;
  // Only the first few mismatches are printed; all of them are counted.
  localparam int unsigned PRINT_CAP = 40;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;
  logic      cfg_we;
  logic      cfg_idx;
  logic [RowW-1:0] cfg_data;

  spreadsheet_cell_address_parser_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  // Free-running clock with a 10 ns period.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run statistics.
  int unsigned cycle_count;
  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned refs_sent;
  int unsigned refs_checked;
  int unsigned settings_used;

  // When set, neither side idles: the closing part of the run streams flat out.
  bit no_idle;

  // Expected results, oldest first, one per reference whose marked last item
  // has been accepted.
  out_item_t expected_results[$];

  // The predictor's copy of the limit registers and of the parse state.
  logic [RowW-1:0] row_cap;
  logic [ColW-1:0] col_cap;
  logic [1:0]      addr_phase;
  logic [ColW-1:0] col_sum;
  logic [RowW-1:0] row_sum;
  logic [1:0]      row_digits;
  bit              lead_zero;
  bit              blank_held;
  bit              stray_seen;

  // Characters of the reference being built, sent in one go by flush_reference.
  logic [CharW-1:0] text_codes[$];
  bit               text_present[$];

  // ------------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------------

  function automatic void clear_parse();
    addr_phase = PH_IDLE;
    col_sum    = '0;
    row_sum    = '0;
    row_digits = '0;
    lead_zero  = 1'b0;
    blank_held = 1'b0;
    stray_seen = 1'b0;
  endfunction

  // Tab, line feed, form feed, carriage return and space are blanks; the
  // vertical tab is deliberately not.
  function automatic bit is_blank(logic [CharW-1:0] c);
    return c == 8'd9 || c == 8'd10 || c == 8'd12 || c == 8'd13 || c == 8'd32;
  endfunction

  function automatic void take_digit(logic [31:0] d);
    logic [31:0] v;
    v = row_sum * 10 + d;
    if (row_digits == 2'd0) lead_zero = (d == 0);
    if (row_digits < 2'd2) row_digits = row_digits + 2'd1;
    row_sum = (v > ROW_SAT) ? ROW_SAT : v[RowW-1:0];
  endfunction

  function automatic void take_char(logic [CharW-1:0] code);
    logic [CharW-1:0] c;
    bit               letter;
    bit               digit;
    logic [31:0]      v;
    c = code;
    if (is_blank(c)) begin
      // A blank after content may turn out to be trailing, so it is held.
      if (addr_phase == PH_LETTERS || addr_phase == PH_DIGITS) blank_held = 1'b1;
      return;
    end
    if (c >= 8'd97 && c <= 8'd122) c = c - 8'd32;
    letter = (c >= 8'd65 && c <= 8'd90);
    digit  = (c >= 8'd48 && c <= 8'd57);
    if (addr_phase == PH_IDLE) begin
      if (letter) begin
        addr_phase = PH_LETTERS;
        col_sum    = ColW'(c - 8'd64);
      end else begin
        addr_phase = PH_FAIL;
      end
      return;
    end
    if (addr_phase == PH_FAIL) return;
    // Content after a held blank makes that blank an interior one.
    if (blank_held) begin
      blank_held = 1'b0;
      addr_phase = PH_DIGITS;
      stray_seen = 1'b1;
    end
    if (addr_phase == PH_LETTERS) begin
      if (letter) begin
        v = col_sum * 26 + (c - 8'd64);
        col_sum = (v > COL_SAT) ? COL_SAT : v[ColW-1:0];
      end else begin
        addr_phase = PH_DIGITS;
        if (digit) take_digit(c - 8'd48);
        else stray_seen = 1'b1;
      end
      return;
    end
    if (digit) take_digit(c - 8'd48);
    else stray_seen = 1'b1;
  endfunction

  // Applies one accepted item; returns 1 and the expected result when the
  // item closes a reference.
  function automatic bit predict_reference_item(in_item_t it, output out_item_t res);
    logic [StatusW-1:0] st;
    res = '0;
    if (it.char_present) take_char(it.char_code);
    if (!it.last_char) return 1'b0;
    if (addr_phase == PH_IDLE) st = ST_EMPTY;
    else if (addr_phase == PH_LETTERS || addr_phase == PH_FAIL) st = ST_FORM;
    else if (stray_seen) st = ST_BAD_CHAR;
    else if (row_digits >= 2'd2 && lead_zero) st = ST_LEAD_ZERO;
    else if (row_sum == '0 || row_sum > row_cap) st = ST_ROW_RANGE;
    else if (col_sum > col_cap) st = ST_COL_RANGE;
    else st = ST_OK;
    res.status = st;
    if (st == ST_OK) begin
      res.row_number    = row_sum;
      res.column_number = col_sum;
    end
    clear_parse();
    return 1'b1;
  endfunction

  // ------------------------------------------------------------------------
  // Checking
  // ------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
  endtask

  // Every result taken by the receiver is matched against the oldest
  // expectation. Sampling at the rising edge sees the values from before it.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected, status %0d", out_item.status));
      end else begin
        want = expected_results.pop_front();
        refs_checked++;
        if (out_item.status !== want.status)
          report_mismatch($sformatf("reference %0d status %0d, expected %0d",
                                    refs_checked, out_item.status, want.status));
        if (out_item.row_number !== want.row_number)
          report_mismatch($sformatf("reference %0d row %0d, expected %0d",
                                    refs_checked, out_item.row_number, want.row_number));
        if (out_item.column_number !== want.column_number)
          report_mismatch($sformatf("reference %0d column %0d, expected %0d",
                                    refs_checked, out_item.column_number,
                                    want.column_number));
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, expected_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver back-pressure: random stall bursts alternate with
  // free-flowing stretches, all changed on the falling edge.
  initial begin
    int unsigned stall_left;
    int unsigned run_left;
    stall_left = 0;
    run_left   = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (no_idle) begin
        out_stall <= 1'b0;
      end else if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (run_left != 0) begin
        out_stall <= 1'b0;
        run_left--;
      end else if ($urandom_range(0, 1) == 1) begin
        out_stall  <= 1'b1;
        stall_left = $urandom_range(0, 16);
      end else begin
        out_stall <= 1'b0;
        run_left  = $urandom_range(0, 39);
      end
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------------

  // Sends one character item, with a random gap beforehand unless the run is
  // in its steady part. The predictor sees the item once it is accepted.
  task automatic send_char_item(logic [CharW-1:0] code, bit present, bit last);
    in_item_t  it;
    out_item_t res;
    it.char_code    = code;
    it.char_present = present;
    it.last_char    = last;
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 16)) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (predict_reference_item(it, res)) begin
      expected_results.push_back(res);
      refs_sent++;
    end
  endtask

  function automatic void add_char(logic [CharW-1:0] c, bit present = 1'b1);
    text_codes.push_back(c);
    text_present.push_back(present);
  endfunction

  function automatic void add_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) add_char(s[i]);
  endfunction

  // Sends the characters built so far, marking the final one as last.
  task automatic flush_reference();
    int i;
    for (i = 0; i < text_codes.size(); i++)
      send_char_item(text_codes[i], text_present[i], i == text_codes.size() - 1);
    text_codes.delete();
    text_present.delete();
  endtask

  // Drops valid, waits for every outstanding result and lets the pipeline
  // settle, so that the block is idle.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(logic idx, logic [RowW-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ROW_LIMIT) row_cap = value;
    else col_cap = value[ColW-1:0];
    settings_used++;
  endtask

  function automatic logic [CharW-1:0] random_blank();
    case ($urandom_range(0, 4))
      0:       return 8'd9;
      1:       return 8'd10;
      2:       return 8'd12;
      3:       return 8'd13;
      default: return 8'd32;
    endcase
  endfunction

  function automatic logic [CharW-1:0] random_letter();
    return 8'd65 + CharW'($urandom_range(0, 25)) + (($urandom_range(0, 1) == 1) ? 8'd32 : 8'd0);
  endfunction

  function automatic logic [CharW-1:0] random_byte();
    return CharW'($urandom_range(0, 255));
  endfunction

  // Builds and sends one random reference. Most are well formed with random
  // content; the rest have a leading zero, a stray byte, an interior blank,
  // no digits, no leading letter, or are plain noise.
  task automatic send_random_reference();
    int unsigned shape;
    int unsigned n;
    int unsigned i;
    shape = $urandom_range(0, 13);
    if (shape == 13) begin
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++) add_char(random_byte(), $urandom_range(0, 4) != 0);
    end else begin
      repeat ($urandom_range(0, 2)) add_char(random_blank());
      if (shape == 12) add_char(($urandom_range(0, 1) == 1) ? 8'd48 + CharW'($urandom_range(0, 9))
                                                            : random_byte());
      // Mostly short column names, now and then long enough to saturate.
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 7) : $urandom_range(1, 3);
      for (i = 0; i < n; i++) begin
        if ($urandom_range(0, 15) == 0) add_char(random_byte(), 1'b0);
        add_char(random_letter());
      end
      if (shape == 10) add_char(($urandom_range(0, 1) == 1) ? random_blank() : random_byte());
      if (shape != 11) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 10) : $urandom_range(1, 7);
        for (i = 0; i < n; i++) begin
          if ($urandom_range(0, 15) == 0) add_char(random_byte(), 1'b0);
          if (i == 0 && shape == 9) add_char(8'd48);
          else if (i == 0 && $urandom_range(0, 9) != 0) add_char(8'd49 + CharW'($urandom_range(0, 8)));
          else add_char(8'd48 + CharW'($urandom_range(0, 9)));
          if (shape == 8 && i == n / 2)
            add_char(($urandom_range(0, 1) == 1) ? random_blank() : random_byte());
        end
      end
      repeat ($urandom_range(0, 2)) add_char(random_blank());
    end
    // Sometimes the reference is closed by an item that carries no character.
    if ($urandom_range(0, 3) == 0) add_char(random_byte(), 1'b0);
    flush_reference();
  endtask

  task automatic run_random_phase(logic [RowW-1:0] row_value, logic [RowW-1:0] col_value,
                                  int unsigned item_target);
    write_limit(REG_ROW_LIMIT, row_value);
    write_limit(REG_COLUMN_LIMIT, col_value);
    while (items_sent < item_target) send_random_reference();
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Short hand-written references under the reset limits: every status but the
  // column range, and each oddity of blanks, case and character presence.
  task automatic test_directed_references();
    // An item with no character, marked last, is an empty reference.
    add_char(8'hA5, 1'b0); flush_reference();
    add_text("A1"); flush_reference();
    // Lower case with a leading tab and a trailing carriage return.
    add_char(8'd9); add_text("zZ9"); add_char(8'd13); flush_reference();
    // A blank between the letters and the digits is a bad character.
    add_text("a 1"); flush_reference();
    // The vertical tab is not a blank, so the first content is not a letter.
    add_char(8'd11); add_text("a1"); flush_reference();
    add_text("ab"); flush_reference();
    add_text("a01"); flush_reference();
    add_text("a0"); flush_reference();
    // Bytes with the top bit set are never letters.
    add_text("a"); add_char(8'hFF); add_text("1"); flush_reference();
    // The closing item carries no character; the result is for "b7".
    add_text("b7"); add_char(8'h00, 1'b0); flush_reference();
  endtask

  // Limit registers at their extremes, including zero and the saturation
  // values, and the exact boundaries of the reset limits.
  task automatic test_limit_boundaries();
    write_limit(REG_ROW_LIMIT, '0);
    add_text("a1"); flush_reference();
    write_limit(REG_ROW_LIMIT, ROW_LIMIT_RST);
    write_limit(REG_COLUMN_LIMIT, '0);
    add_text("a1"); flush_reference();
    // With both limits at saturation, saturated accumulators pass.
    write_limit(REG_ROW_LIMIT, ROW_SAT);
    write_limit(REG_COLUMN_LIMIT, RowW'(COL_SAT));
    add_text("aaaaa99999999"); flush_reference();
    add_text("Zz2097151"); flush_reference();
    // Data bits above the column register are dropped.
    write_limit(REG_COLUMN_LIMIT, 21'h1F8005);
    add_text("e1"); flush_reference();
    add_text("f1"); flush_reference();
    write_limit(REG_ROW_LIMIT, 21'd1);
    add_text("a1"); flush_reference();
    add_text("a2"); flush_reference();
    write_limit(REG_ROW_LIMIT, ROW_LIMIT_RST);
    write_limit(REG_COLUMN_LIMIT, RowW'(COLUMN_LIMIT_RST));
    add_text("xfd1048576"); flush_reference();
    add_text("XFE1"); flush_reference();
    add_text("a1048577"); flush_reference();
  endtask

  // Random references under several limit settings, with idling on both sides.
  task automatic test_random_references();
    run_random_phase(ROW_LIMIT_RST, RowW'(COLUMN_LIMIT_RST), 160);
    run_random_phase(RowW'($urandom_range(1, 99999)), RowW'($urandom_range(1, 800)), 260);
    run_random_phase(ROW_SAT, RowW'(COL_SAT), 360);
    run_random_phase(RowW'($urandom_range(1, ROW_SAT)), RowW'($urandom_range(0, COL_SAT)), 440);
    run_random_phase(21'd50, 21'd30, 520);
  endtask

  // The closing stretch: back-to-back items and no receiver stalls.
  task automatic test_steady_stream();
    write_limit(REG_ROW_LIMIT, ROW_LIMIT_RST);
    write_limit(REG_COLUMN_LIMIT, RowW'(COLUMN_LIMIT_RST));
    no_idle = 1'b1;
    while (items_sent < 640) send_random_reference();
  endtask

  // ------------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------------

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    cfg_we   = 1'b0;
    cfg_idx  = REG_ROW_LIMIT;
    cfg_data = '0;
    no_idle  = 1'b0;
    row_cap  = ROW_LIMIT_RST;
    col_cap  = COLUMN_LIMIT_RST;
    clear_parse();

    // Reset is held from time zero and released on a falling edge.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_references();
    test_limit_boundaries();
    test_random_references();
    test_steady_stream();

    wait_drained();
    $display("Covered %0d cell references in %0d character items under %0d limit writes,",
             refs_checked, items_sent, settings_used);
    $display("with random idling on both sides and a final stretch at full rate.");
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches found.", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
